FILE: rtl/iol_pkg.sv
`default_nettype none
package iol_pkg;

    localparam int DataW   = 32;
    localparam int OpW     = 3;
    localparam int FieldPW = 5;
    localparam int StatW   = 2;
    localparam int InW     = 40;
    localparam int OutW    = 40;

    typedef enum logic [OpW-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_APPEND     = 3'd1,
        OP_INSERT     = 3'd2,
        OP_READ       = 3'd3,
        OP_DELETE     = 3'd4
    } iol_op_t;

    typedef enum logic [StatW-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } iol_status_t;

    typedef struct packed {
        logic ins;
        logic del;
    } iol_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/indexed_ordered_list.sv
// channel | ports           | word layout (lsb first)
// input   | s_tvalid/tready | opcode[2:0] position[7:3] value[39:8]
// result  | m_tvalid/tready | status[1:0] read_value[33:2] element_count[38:34]
// one word per cycle while s_tready is high; each request completes in the row of
// cells as it is taken; shifting cells move together; result in one output register
// input is taken while the output register is empty or being drained
// reset clears count and output valid only; element storage needs no clearing
`default_nettype none
module indexed_ordered_list #(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [iol_pkg::InW-1:0]  s_tdata,  // opcode, position, value
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [iol_pkg::OutW-1:0] m_tdata   // status, read_value, element_count
);
    import iol_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > FieldPW) ? CW : FieldPW;

    logic [OpW-1:0]     s_opcode;
    logic [FieldPW-1:0] s_position;
    logic [DataW-1:0]   s_value;
    logic               acc;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               m_valid_reg;
    logic [StatW-1:0]   status_reg;
    logic [DataW-1:0]   rd_reg;
    logic [FieldPW-1:0] cnt_out_reg;

    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      cnt_ext;
    logic               full;
    logic [StatW-1:0]   status_next;
    logic               do_ins;
    logic               do_del;
    logic               do_rd;
    logic [CW-1:0]      cmd_pos;
    iol_cmd_t           cmd;
    logic [DataW-1:0]   rd_any;

    logic [DataW-1:0]   cell_data [DEPTH];
    logic [DataW-1:0]   cell_rd   [DEPTH];

    assign s_opcode   = s_tdata[2:0];
    assign s_position = s_tdata[7:3];
    assign s_value    = s_tdata[39:8];

    assign s_tready = !m_valid_reg || m_tready;
    assign acc      = s_tvalid && s_tready;

    assign pos_ext = PW'(s_position);
    assign cnt_ext = PW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));

    always_comb begin
        status_next = ST_DONE;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_rd       = 1'b0;
        cmd_pos     = CW'(pos_ext);
        unique case (s_opcode)
            OP_PUSH_FRONT: begin
                cmd_pos = '0;
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_APPEND: begin
                cmd_pos = count_reg;
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status_next = ST_RANGE;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_READ: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    do_rd = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = ST_RANGE;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
                status_next = ST_RANGE;
            end
        endcase
    end

    assign cmd.ins = acc && do_ins;
    assign cmd.del = acc && do_del;

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.del) begin
            count_next = count_reg - 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DataW-1:0] left_d;
            logic [DataW-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_left
                assign left_d = cell_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_right
                assign right_d = cell_data[g+1];
            end
            iol_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .pos        (cmd_pos),
                .value      (s_value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .rd_data    (cell_rd[g])
            );
        end
    endgenerate

    always_comb begin
        rd_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (acc) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            status_reg  <= status_next;
            rd_reg      <= do_rd ? rd_any : '0;
            cnt_out_reg <= FieldPW'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, rd_reg, status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && status_next == ST_FULL) |=> count_reg == $past(count_reg))
        else $error("full request changed count");

    a_ins_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("insert did not grow count");

    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg != ST_DONE) |-> rd_reg == '0)
        else $error("read value on failed request");

endmodule
`default_nettype wire

FILE: rtl/iol_cell.sv
`default_nettype none
module iol_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                      aclk,
    input  wire iol_pkg::iol_cmd_t         cmd,
    input  wire logic [CW-1:0]             pos,
    input  wire logic [iol_pkg::DataW-1:0] value,
    input  wire logic [iol_pkg::DataW-1:0] left_data,
    input  wire logic [iol_pkg::DataW-1:0] right_data,
    output logic      [iol_pkg::DataW-1:0] data,
    output logic      [iol_pkg::DataW-1:0] rd_data
);
    import iol_pkg::*;

    logic [DataW-1:0] data_reg;
    logic [DataW-1:0] data_next;
    logic             at_pos;
    logic             after_pos;

    assign at_pos    = (pos == CW'(IDX));
    assign after_pos = (CW'(IDX) > pos);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (at_pos) begin
                data_next = value;
            end else if (after_pos) begin
                data_next = left_data;
            end
        end else if (cmd.del) begin
            if (at_pos || after_pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = at_pos ? data_reg : '0;

endmodule
`default_nettype wire
